/* rtl/segmented_range_splitter_unit_defines.svh */
// assertion macros for the segmented range splitter
// used by the top level; expects i_clk and i_rst_n in scope
`ifndef SEGMENTED_RANGE_SPLITTER_UNIT_DEFINES_SVH
`define SEGMENTED_RANGE_SPLITTER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled while in reset
`define SRS_ASSERT_IMP(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);
// next-cycle implication, disabled while in reset
`define SRS_ASSERT_NXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define SRS_ASSERT_IMP(label, pre, post, msg)
`define SRS_ASSERT_NXT(label, pre, post, msg)
`endif
`endif

/* rtl/srs_pkg.sv */
// shared types and codes for the segmented range splitter
// no dependencies; imported by controller, datapath and top level
`default_nettype none

package srs_pkg;

    typedef enum logic [1:0] {
        CMD_ADD       = 2'd0,
        CMD_WRITE_AT  = 2'd1,
        CMD_WRITE_SEQ = 2'd2,
        CMD_PLAN      = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_SUM_OVF    = 3'd1,
        ST_BEYOND     = 3'd2,
        ST_UNMAPPED   = 3'd3,
        ST_LAYOUT_OVF = 3'd4,
        ST_TABLE_FULL = 3'd5
    } t_status;

    // which kind of result the output register is loaded with
    typedef enum logic [1:0] {
        OUT_ERR   = 2'd0,
        OUT_ADD   = 2'd1,
        OUT_EMPTY = 2'd2,
        OUT_WIN   = 2'd3
    } t_out_kind;

    typedef struct packed {
        t_cmd        command;
        logic [63:0] request_offset;
        logic [63:0] item_length;
        logic [63:0] segment_base_address;
        logic        segment_stable;
    } t_item;

    typedef struct packed {
        t_status     status;
        logic [3:0]  segment_index;
        logic [63:0] layout_offset;
        logic [63:0] seg_offset;
        logic [63:0] local_address;
        logic [63:0] window_length;
        logic        window_stable;
        logic        last;
    } t_result;

    // controller to datapath
    typedef struct packed {
        logic      load_item;
        logic      calc_sum;
        logic      add_seg;
        logic      scan_start;
        logic      set_cursor;
        logic      set_sticky;
        t_status   code;
        logic      out_load;
        t_out_kind out_kind;
        logic      next_seg;
        logic      advance;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        t_cmd    command;
        t_status sticky;
        logic    table_full;
        logic    sum_carry;
        logic    beyond;
        logic    len_zero;
        logic    hit;
        logic    win_last;
        logic    out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

/* rtl/srs_stream_if.sv */
// valid/ready channel interfaces for items in and results out
// no dependencies
`default_nettype none

interface srs_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [63:0] request_offset;
    logic [63:0] item_length;
    logic [63:0] segment_base_address;
    logic        segment_stable;

    modport source (
        output valid, command, request_offset, item_length, segment_base_address,
               segment_stable,
        input  ready
    );
    modport sink (
        input  valid, command, request_offset, item_length, segment_base_address,
               segment_stable,
        output ready
    );
endinterface

interface srs_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [3:0]  segment_index;
    logic [63:0] layout_offset;
    logic [63:0] seg_offset;
    logic [63:0] local_address;
    logic [63:0] window_length;
    logic        window_stable;
    logic        last;

    modport source (
        output valid, status, segment_index, layout_offset, seg_offset, local_address,
               window_length, window_stable, last,
        input  ready
    );
    modport sink (
        input  valid, status, segment_index, layout_offset, seg_offset, local_address,
               window_length, window_stable, last,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/srs_datapath.sv */
// datapath: item registers, segment table memory, range arithmetic, output register
// depends on srs_pkg
`default_nettype none

module srs_datapath
    import srs_pkg::*;
#(
    parameter int MAX_SEGMENTS = 16
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_item   i_item,
    input  wire t_dp_cmd i_cmd,
    output t_dp_sts      o_sts,
    output t_result      o_result,
    output logic         o_out_valid,
    input  wire logic    i_out_ready
);

    localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

    typedef struct packed {
        logic [63:0] seg_start;
        logic [63:0] seg_end;
        logic [63:0] seg_base;
        logic        seg_stable;
    } t_seg;

    t_seg r_seg_mem [MAX_SEGMENTS];
    t_seg r_rd;

    t_cmd        r_cmd;
    logic [63:0] r_off;
    logic [63:0] r_len;
    logic [63:0] r_base;
    logic        r_stable;
    logic [64:0] r_sum;
    logic [CNT_W-1:0] r_count;
    logic [63:0] r_total;
    logic [63:0] r_cursor;
    t_status     r_sticky;
    logic [IDX_W-1:0] r_idx;
    logic [63:0] r_pos;
    logic [63:0] r_left;
    logic [63:0] r_loff;
    logic [63:0] r_avail;
    t_result     r_out;
    logic        r_out_valid;

    logic [63:0] sum_a;
    logic        win_last;
    logic        out_free;
    logic [CNT_W+3:0] count_ext;
    logic [IDX_W+3:0] idx_ext;
    t_result     n_out;

    // adder operand: layout end for adds, range start otherwise
    assign sum_a    = (r_cmd == CMD_ADD) ? r_total : r_off;
    assign win_last = (r_left <= r_avail);
    assign out_free = !r_out_valid || i_out_ready;
    assign count_ext = {4'b0000, r_count};
    assign idx_ext   = {4'b0000, r_idx};

    // status to controller
    always_comb begin
        o_sts            = '0;
        o_sts.command    = r_cmd;
        o_sts.sticky     = r_sticky;
        o_sts.table_full = (r_count == CNT_W'(MAX_SEGMENTS));
        o_sts.sum_carry  = r_sum[64];
        o_sts.beyond     = (r_sum[63:0] > r_total);
        o_sts.len_zero   = (r_len == 64'd0);
        o_sts.hit        = (r_pos < r_rd.seg_end);
        o_sts.win_last   = win_last;
        o_sts.out_free   = out_free;
    end

    // next result
    always_comb begin
        n_out = '0;
        unique case (i_cmd.out_kind)
            OUT_ERR: begin
                n_out.status = i_cmd.code;
                n_out.last   = 1'b1;
            end
            OUT_EMPTY: begin
                n_out.status = ST_OK;
                n_out.last   = 1'b1;
            end
            OUT_ADD: begin
                n_out.status        = ST_OK;
                n_out.segment_index = count_ext[3:0];
                n_out.layout_offset = r_total;
                n_out.local_address = r_base;
                n_out.window_length = r_len;
                n_out.window_stable = r_stable;
                n_out.last          = 1'b1;
            end
            OUT_WIN: begin
                n_out.status        = ST_OK;
                n_out.segment_index = idx_ext[3:0];
                n_out.layout_offset = r_pos;
                n_out.seg_offset    = r_loff;
                n_out.local_address = r_rd.seg_base + r_loff;
                n_out.window_length = win_last ? r_left : r_avail;
                n_out.window_stable = r_rd.seg_stable;
                n_out.last          = win_last;
            end
            default: n_out = '0;
        endcase
    end

    // control state: table fill, layout total, cursor, sticky error, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_total     <= '0;
            r_cursor    <= '0;
            r_sticky    <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.add_seg) begin
                r_count <= r_count + CNT_W'(1);
                r_total <= r_sum[64] ? 64'd0 : r_sum[63:0];
            end
            if (i_cmd.set_cursor) begin
                r_cursor <= r_sum[63:0];
            end
            if (i_cmd.set_sticky) begin
                r_sticky <= i_cmd.code;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item capture, range arithmetic and scan registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_cmd    <= i_item.command;
            r_off    <= (i_item.command == CMD_WRITE_SEQ) ? r_cursor : i_item.request_offset;
            r_len    <= i_item.item_length;
            r_base   <= i_item.segment_base_address;
            r_stable <= i_item.segment_stable;
        end
        if (i_cmd.calc_sum) begin
            r_sum <= {1'b0, sum_a} + {1'b0, r_len};
        end
        if (i_cmd.scan_start) begin
            r_idx  <= '0;
            r_pos  <= r_off;
            r_left <= r_len;
        end else begin
            if (i_cmd.next_seg) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            if (i_cmd.advance) begin
                r_pos  <= r_rd.seg_end;
                r_left <= r_left - r_avail;
            end
        end
        // window position inside the segment just read
        r_loff  <= r_pos - r_rd.seg_start;
        r_avail <= r_rd.seg_end - r_pos;
        if (i_cmd.out_load) begin
            r_out <= n_out;
        end
    end

    // segment table, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.add_seg) begin
            r_seg_mem[r_count[IDX_W-1:0]] <= '{seg_start:  r_total,
                                               seg_end:    r_sum[63:0],
                                               seg_base:   r_base,
                                               seg_stable: r_stable};
        end
        r_rd <= r_seg_mem[r_idx];
    end

    assign o_result    = r_out;
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

/* rtl/srs_ctrl.sv */
// controller: sequences item decode, error handling and the segment scan
// depends on srs_pkg
`default_nettype none

module srs_ctrl
    import srs_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_DECIDE,
        S_READ,
        S_CHECK,
        S_WIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   is_write;

    assign is_write   = (i_sts.command != CMD_PLAN);
    assign o_in_ready = (r_state == S_IDLE);

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_SUM;
                end
            end
            S_SUM: begin
                o_cmd.calc_sum = 1'b1;
                n_state        = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                    priority if (i_sts.sticky != ST_OK) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_kind = OUT_ERR;
                        o_cmd.code     = i_sts.sticky;
                    end else if (i_sts.command == CMD_ADD) begin
                        o_cmd.out_load = 1'b1;
                        if (i_sts.table_full) begin
                            o_cmd.out_kind   = OUT_ERR;
                            o_cmd.code       = ST_TABLE_FULL;
                            o_cmd.set_sticky = 1'b1;
                        end else begin
                            o_cmd.add_seg = 1'b1;
                            if (i_sts.sum_carry) begin
                                o_cmd.out_kind   = OUT_ERR;
                                o_cmd.code       = ST_LAYOUT_OVF;
                                o_cmd.set_sticky = 1'b1;
                            end else begin
                                o_cmd.out_kind = OUT_ADD;
                            end
                        end
                    end else if (i_sts.len_zero) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_kind = OUT_EMPTY;
                    end else if (i_sts.sum_carry) begin
                        o_cmd.out_load   = 1'b1;
                        o_cmd.out_kind   = OUT_ERR;
                        o_cmd.code       = ST_SUM_OVF;
                        o_cmd.set_sticky = is_write;
                    end else if (i_sts.beyond) begin
                        o_cmd.out_load   = 1'b1;
                        o_cmd.out_kind   = OUT_ERR;
                        o_cmd.code       = ST_BEYOND;
                        o_cmd.set_sticky = is_write;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        o_cmd.set_cursor = (i_sts.command == CMD_WRITE_SEQ);
                        n_state          = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                // skip segments that end at or before the current position
                if (i_sts.hit) begin
                    n_state = S_WIN;
                end else begin
                    o_cmd.next_seg = 1'b1;
                    n_state        = S_READ;
                end
            end
            S_WIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = OUT_WIN;
                    if (i_sts.win_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.advance  = 1'b1;
                        o_cmd.next_seg = 1'b1;
                        n_state        = S_READ;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

/* rtl/segmented_range_splitter_unit.sv */
// Segmented range splitter. Segments added with command 0 are laid end to end in one linear
// byte space; commands 1 to 3 give a byte range that is checked and then cut into one window
// per segment touched, each carrying global offset, local offset, local address, length and
// stable flag, with last set on the final window. Errors from adds and writes stick and are
// returned for every later item. One item is handled at a time. Adds, errors and zero-length
// ranges pass through the idle, sum and decide states; a range then scans the segment table,
// which sits in a memory with one write port and one registered read port, from entry 0,
// each entry taking a read and a check state, and issues each window from a window state. A
// result waiting in the output register does not hold off the next item; output stalls hold
// the controller in its decide or window state.
// depends on srs_pkg, srs_stream_if, srs_datapath, srs_ctrl and the assertion macro header
`default_nettype none
`include "segmented_range_splitter_unit_defines.svh"

module segmented_range_splitter_unit
    import srs_pkg::*;
#(
    parameter int MAX_SEGMENTS = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    srs_in_if.sink     i_in,
    srs_out_if.source  o_out
);

    t_item   item;
    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;
    t_result result;
    logic    out_valid;

    // input item fields
    always_comb begin
        item.command              = t_cmd'(i_in.command);
        item.request_offset       = i_in.request_offset;
        item.item_length          = i_in.item_length;
        item.segment_base_address = i_in.segment_base_address;
        item.segment_stable       = i_in.segment_stable;
    end

    srs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    srs_datapath #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .o_result    (result),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready)
    );

    // result fields
    assign o_out.valid         = out_valid;
    assign o_out.status        = result.status;
    assign o_out.segment_index = result.segment_index;
    assign o_out.layout_offset = result.layout_offset;
    assign o_out.seg_offset    = result.seg_offset;
    assign o_out.local_address = result.local_address;
    assign o_out.window_length = result.window_length;
    assign o_out.window_stable = result.window_stable;
    assign o_out.last          = result.last;

    // output register is only loaded when free or being drained
    `SRS_ASSERT_IMP(a_out_load_free, dp_cmd.out_load, !o_out.valid || o_out.ready, "output overwritten")
    // a sticky error never changes once set
    `SRS_ASSERT_NXT(a_sticky_hold, dp_sts.sticky != ST_OK, dp_sts.sticky == $past(dp_sts.sticky), "sticky error changed")
    // error results are always single results
    `SRS_ASSERT_IMP(a_err_last, o_out.valid && (o_out.status != ST_OK), o_out.last, "error result without last")

endmodule

`default_nettype wire

/* sim/tb_segmented_range_splitter_unit.sv */
`timescale 1ns / 1ps
// self-checking testbench for segmented_range_splitter_unit: a directed table, random items
// checked against an in-bench model of the segment table, then one sticky error at the end
// depends on srs_pkg, srs_stream_if and the rtl top level

module tb_segmented_range_splitter_unit;
    import srs_pkg::*;

    localparam int          MAX_SEG      = 16;
    localparam int          RANDOM_ITEMS = 70;
    localparam int          CALM_ITEMS   = 20;
    localparam int          DRAIN_CYCLES = 80;
    localparam logic [63:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct {
        t_item   item;
        bit      typed;
        t_result want;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;
    bit   idle_on;
    int   mismatch_count = 0;

    srs_in_if  in_ch ();
    srs_out_if out_ch ();

    // mirror of the segment table, layout size, cursor and sticky error
    logic [63:0] seg_start  [MAX_SEG];
    logic [63:0] seg_size   [MAX_SEG];
    logic [63:0] seg_base   [MAX_SEG];
    logic        seg_stable [MAX_SEG];
    int          seg_count   = 0;
    logic [63:0] layout_size = '0;
    logic [63:0] cursor      = '0;
    t_status     sticky      = ST_OK;

    t_result  item_windows[$];
    t_result  pending_windows[$];
    t_dir_row directed_rows[$];

    segmented_range_splitter_unit #(
        .MAX_SEGMENTS(MAX_SEG)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic t_result pack_window(t_status st, logic [3:0] idx, logic [63:0] goff,
                                            logic [63:0] loff, logic [63:0] addr,
                                            logic [63:0] len, logic stable, logic last);
        t_result r;
        r.status        = st;
        r.segment_index = idx;
        r.layout_offset = goff;
        r.seg_offset    = loff;
        r.local_address = addr;
        r.window_length = len;
        r.window_stable = stable;
        r.last          = last;
        return r;
    endfunction

    // error results and empty ranges: status only, last set
    function automatic t_result bare_result(t_status st);
        return pack_window(st, '0, '0, '0, '0, '0, 1'b0, 1'b1);
    endfunction

    function automatic t_item make_item(t_cmd cmd, logic [63:0] off, logic [63:0] len,
                                        logic [63:0] base, logic stable);
        t_item it;
        it.command              = cmd;
        it.request_offset       = off;
        it.item_length          = len;
        it.segment_base_address = base;
        it.segment_stable       = stable;
        return it;
    endfunction

    function automatic int locate_segment(logic [63:0] pos);
        int i;
        for (i = 0; i < seg_count; i++) begin
            if (pos >= seg_start[i] && pos - seg_start[i] < seg_size[i]) return i;
        end
        return -1;
    endfunction

    // cut a range into windows, one per segment touched
    function automatic t_status split_range(logic [63:0] off, logic [63:0] len);
        logic [64:0] span_end;
        logic [63:0] pos;
        logic [63:0] left;
        logic [63:0] loff;
        logic [63:0] take;
        int          idx;
        if (len == 64'd0) begin
            item_windows.insert(item_windows.size(), bare_result(ST_OK));
            return ST_OK;
        end
        span_end = {1'b0, off} + {1'b0, len};
        if (span_end[64]) return ST_SUM_OVF;
        if (span_end[63:0] > layout_size) return ST_BEYOND;
        pos  = off;
        left = len;
        while (left != 64'd0) begin
            idx = locate_segment(pos);
            if (idx < 0 || item_windows.size() >= MAX_SEG) begin
                item_windows.delete();
                return ST_UNMAPPED;
            end
            loff = pos - seg_start[idx];
            take = seg_size[idx] - loff;
            if (left < take) take = left;
            left -= take;
            item_windows.insert(item_windows.size(),
                                pack_window(ST_OK, 4'(idx), pos, loff, seg_base[idx] + loff,
                                            take, seg_stable[idx], left == 64'd0));
            pos += take;
        end
        return ST_OK;
    endfunction

    // results of one accepted item, with the state update it causes
    function automatic void predict_windows(t_item it);
        logic [63:0] off;
        t_status     st;
        int          slot;
        item_windows.delete();
        if (sticky != ST_OK) begin
            item_windows.insert(item_windows.size(), bare_result(sticky));
            return;
        end
        case (it.command)
            CMD_ADD: begin
                slot = seg_count;
                if (slot >= MAX_SEG) begin
                    sticky = ST_TABLE_FULL;
                    item_windows.insert(item_windows.size(), bare_result(sticky));
                    return;
                end
                seg_start[slot]  = layout_size;
                seg_size[slot]   = it.item_length;
                seg_base[slot]   = it.segment_base_address;
                seg_stable[slot] = it.segment_stable;
                seg_count        = slot + 1;
                if (it.item_length > ~layout_size) begin
                    layout_size = '0;
                    sticky      = ST_LAYOUT_OVF;
                    item_windows.insert(item_windows.size(), bare_result(sticky));
                end else begin
                    item_windows.insert(item_windows.size(),
                                        pack_window(ST_OK, 4'(slot), layout_size, '0,
                                                    it.segment_base_address, it.item_length,
                                                    it.segment_stable, 1'b1));
                    layout_size += it.item_length;
                end
            end
            CMD_PLAN: begin
                st = split_range(it.request_offset, it.item_length);
                if (st != ST_OK) item_windows.insert(item_windows.size(), bare_result(st));
            end
            default: begin
                off = (it.command == CMD_WRITE_SEQ) ? cursor : it.request_offset;
                st  = split_range(off, it.item_length);
                if (st != ST_OK) begin
                    sticky = st;
                    item_windows.insert(item_windows.size(), bare_result(st));
                end else if (it.command == CMD_WRITE_SEQ) begin
                    cursor = off + it.item_length;
                end
            end
        endcase
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] rand_between(logic [63:0] lo, logic [63:0] hi);
        logic [63:0] span;
        span = hi - lo + 64'd1;
        if (span == 64'd0) return rand64();
        return lo + rand64() % span;
    endfunction

    // mostly small segments, some huge; sixteen of them cannot overflow the layout
    function automatic logic [63:0] random_segment_len();
        case ($urandom_range(0, 9))
            0:       return 64'd0;
            1, 2, 3: return rand_between(64'd1, 64'd16);
            4, 5, 6: return rand_between(64'd17, 64'd4096);
            7, 8:    return rand64() >> 5;
            default: return 64'd1 << $urandom_range(0, 58);
        endcase
    endfunction

    // a byte inside the layout, often at a segment edge
    function automatic logic [63:0] pick_position();
        int j;
        do begin
            j = $urandom_range(0, seg_count - 1);
        end while (seg_size[j] == 64'd0);
        case ($urandom_range(0, 3))
            0:       return seg_start[j];
            1:       return seg_start[j] + seg_size[j] - 64'd1;
            default: return seg_start[j] + rand_between(64'd0, seg_size[j] - 64'd1);
        endcase
    endfunction

    // an end in (lo, layout_size], in any segment past lo
    function automatic logic [63:0] pick_end(logic [63:0] lo);
        int          cand[$];
        int          i;
        int          j;
        logic [63:0] seg_end;
        logic [63:0] first;
        for (i = 0; i < seg_count; i++) begin
            if (seg_size[i] != 64'd0 && seg_start[i] + seg_size[i] > lo) begin
                cand.insert(cand.size(), i);
            end
        end
        j       = cand[$urandom_range(0, cand.size() - 1)];
        seg_end = seg_start[j] + seg_size[j];
        first   = (seg_start[j] > lo) ? seg_start[j] + 64'd1 : lo + 64'd1;
        if ($urandom_range(0, 3) == 0) return seg_end;
        return rand_between(first, seg_end);
    endfunction

    // mostly well-formed ranges so that no sticky error ends the run early
    function automatic t_item next_random_item();
        t_item       it;
        int          pick;
        logic [63:0] off;
        it   = make_item(CMD_PLAN, rand64(), rand64(), rand64(), 1'($urandom_range(0, 1)));
        pick = $urandom_range(0, 99);
        if (layout_size == 64'd0 || (pick < 12 && seg_count < MAX_SEG - 1)) begin
            it.command     = CMD_ADD;
            it.item_length = random_segment_len();
        end else if (pick < 35) begin
            it.command        = CMD_WRITE_AT;
            off               = pick_position();
            it.request_offset = off;
            it.item_length    = pick_end(off) - off;
        end else if (pick < 55) begin
            it.command     = CMD_WRITE_SEQ;
            it.item_length = (cursor < layout_size) ? pick_end(cursor) - cursor : 64'd0;
        end else if (pick < 85) begin
            off               = pick_position();
            it.request_offset = off;
            it.item_length    = pick_end(off) - off;
        end else if (pick < 95) begin
            // failing plan: just past the end, or wild fields
            if ($urandom_range(0, 1) == 1) begin
                off               = pick_position();
                it.request_offset = off;
                it.item_length    = layout_size - off + rand_between(64'd1, 64'd8);
            end
        end else begin
            it.command     = t_cmd'($urandom_range(1, 3));
            it.item_length = 64'd0;
        end
        return it;
    endfunction

    // drive one item, wait for acceptance, then queue what it should produce
    task automatic send_item(t_item it, bit typed = 1'b0, t_result want = '0);
        int k;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        in_ch.valid                <= 1'b1;
        in_ch.command              <= it.command;
        in_ch.request_offset       <= it.request_offset;
        in_ch.item_length          <= it.item_length;
        in_ch.segment_base_address <= it.segment_base_address;
        in_ch.segment_stable       <= it.segment_stable;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
        predict_windows(it);
        if (typed) begin
            pending_windows.insert(pending_windows.size(), want);
        end else begin
            for (k = 0; k < item_windows.size(); k++) begin
                pending_windows.insert(pending_windows.size(), item_windows[k]);
            end
        end
    endtask

    function automatic void stage_row(t_cmd cmd, logic [63:0] off, logic [63:0] len,
                                      logic [63:0] base, logic stable, bit typed = 1'b0,
                                      t_result want = '0);
        t_dir_row row;
        row.item  = make_item(cmd, off, len, base, stable);
        row.typed = typed;
        row.want  = want;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    function automatic void report_mismatch(string what, t_result want, t_result got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t mismatch: %s", $realtime, what);
            $display("  exp st=%0d idx=%0d goff=%h loff=%h addr=%h len=%h stb=%b last=%b",
                     want.status, want.segment_index, want.layout_offset, want.seg_offset,
                     want.local_address, want.window_length, want.window_stable, want.last);
            $display("  got st=%0d idx=%0d goff=%h loff=%h addr=%h len=%h stb=%b last=%b",
                     got.status, got.segment_index, got.layout_offset, got.seg_offset,
                     got.local_address, got.window_length, got.window_stable, got.last);
        end
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            got = pack_window(t_status'(out_ch.status), out_ch.segment_index,
                              out_ch.layout_offset, out_ch.seg_offset, out_ch.local_address,
                              out_ch.window_length, out_ch.window_stable, out_ch.last);
            if (pending_windows.size() == 0) begin
                report_mismatch("result with nothing expected", '0, got);
            end else begin
                want = pending_windows.pop_front();
                if (got.status !== want.status || got.segment_index !== want.segment_index ||
                    got.layout_offset !== want.layout_offset ||
                    got.seg_offset !== want.seg_offset ||
                    got.local_address !== want.local_address ||
                    got.window_length !== want.window_length ||
                    got.window_stable !== want.window_stable || got.last !== want.last) begin
                    report_mismatch("wrong result field", want, got);
                end
            end
        end
    end

    // result side back-pressure: stall bursts between runs of ready
    initial begin
        out_ch.ready = 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (idle_on && $urandom_range(0, 2) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
        end
    end

    // stimulus
    initial begin
        t_item tail_item;
        int    k;
        in_ch.valid                = 1'b0;
        in_ch.command              = CMD_ADD;
        in_ch.request_offset       = '0;
        in_ch.item_length          = '0;
        in_ch.segment_base_address = '0;
        in_ch.segment_stable       = 1'b0;
        idle_on                    = 1'b1;
        i_rst_n                    = 1'b0;

        // empty layout: zero-length ranges and range errors
        stage_row(CMD_PLAN, '0, '0, '0, 1'b0, 1'b1, bare_result(ST_OK));
        stage_row(CMD_WRITE_SEQ, ALL_ONES, '0, ALL_ONES, 1'b1, 1'b1, bare_result(ST_OK));
        stage_row(CMD_WRITE_AT, ALL_ONES, '0, '0, 1'b0, 1'b1, bare_result(ST_OK));
        stage_row(CMD_PLAN, '0, 64'd1, '0, 1'b0, 1'b1, bare_result(ST_BEYOND));
        stage_row(CMD_PLAN, ALL_ONES, 64'd1, '0, 1'b0, 1'b1, bare_result(ST_SUM_OVF));
        stage_row(CMD_PLAN, 64'd1, ALL_ONES, '0, 1'b0, 1'b1, bare_result(ST_SUM_OVF));
        stage_row(CMD_PLAN, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, '0, 1'b0,
                  1'b1, bare_result(ST_BEYOND));
        stage_row(CMD_PLAN, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, '0, 1'b0,
                  1'b1, bare_result(ST_SUM_OVF));
        // segments, one of them empty, one with a wrapping base
        stage_row(CMD_ADD, '0, 64'd100, ALL_ONES, 1'b1, 1'b1,
                  pack_window(ST_OK, 4'd0, 64'd0, '0, ALL_ONES, 64'd100, 1'b1, 1'b1));
        stage_row(CMD_ADD, '0, '0, 64'h5555_5555_5555_5555, 1'b0, 1'b1,
                  pack_window(ST_OK, 4'd1, 64'd100, '0, 64'h5555_5555_5555_5555, '0, 1'b0,
                              1'b1));
        stage_row(CMD_ADD, ALL_ONES, 64'd50, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        stage_row(CMD_ADD, '0, 64'h100_0000_0000, 64'h0123_4567_89AB_CDEF, 1'b1);
        // ranges over the table: single segment, across the empty one, writes, whole layout
        stage_row(CMD_PLAN, '0, 64'd100, '0, 1'b0);
        stage_row(CMD_PLAN, 64'd99, 64'd2, '0, 1'b0);
        stage_row(CMD_WRITE_AT, 64'd10, 64'd200, '0, 1'b0);
        stage_row(CMD_WRITE_SEQ, ALL_ONES, 64'd150, '0, 1'b0);
        stage_row(CMD_WRITE_SEQ, '0, 64'd1, '0, 1'b0);
        stage_row(CMD_PLAN, '0, 64'h100_0000_0096, '0, 1'b0);
        stage_row(CMD_PLAN, 64'h100_0000_0095, 64'd1, '0, 1'b0);
        stage_row(CMD_PLAN, 64'h100_0000_0096, 64'd1, '0, 1'b0, 1'b1, bare_result(ST_BEYOND));
        stage_row(CMD_PLAN, 64'h100_0000_0095, 64'd2, '0, 1'b0, 1'b1, bare_result(ST_BEYOND));
        stage_row(CMD_PLAN, ALL_ONES, ALL_ONES, '0, 1'b0, 1'b1, bare_result(ST_SUM_OVF));
        stage_row(CMD_ADD, '0, 64'd7, '0, 1'b1);
        stage_row(CMD_WRITE_AT, 64'd149, 64'h100_0000_0008, '0, 1'b0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < directed_rows.size(); k++) begin
            send_item(directed_rows[k].item, directed_rows[k].typed, directed_rows[k].want);
        end

        for (k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == RANDOM_ITEMS - CALM_ITEMS) idle_on = 1'b0;
            send_item(next_random_item());
        end

        // one sticky error, then items that must all return it
        case ($urandom_range(0, 3))
            0: begin
                while (seg_count < MAX_SEG) begin
                    send_item(make_item(CMD_ADD, rand64(), rand_between(64'd0, 64'd64), rand64(),
                                        1'($urandom_range(0, 1))));
                end
                send_item(make_item(CMD_ADD, rand64(), random_segment_len(), rand64(), 1'b1));
            end
            1: begin
                send_item(make_item(CMD_ADD, rand64(), rand_between(~layout_size + 64'd1,
                                    ALL_ONES), rand64(), 1'($urandom_range(0, 1))));
            end
            2: begin
                tail_item                = make_item(CMD_WRITE_AT, rand_between(64'd1, ALL_ONES),
                                                     '0, rand64(), 1'b0);
                tail_item.item_length    = rand_between(~tail_item.request_offset + 64'd1,
                                                        ALL_ONES);
                send_item(tail_item);
            end
            default: begin
                send_item(make_item(CMD_WRITE_SEQ, rand64(),
                                    layout_size - cursor + rand_between(64'd1, 64'd1000),
                                    rand64(), 1'b0));
            end
        endcase
        repeat (4) send_item(next_random_item());

        in_ch.valid <= 1'b0;
        while (pending_windows.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_windows.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
